// File: rtl/core/wfpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wfpa_pkg;

  // Table geometry
  localparam int PARTITIONS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

  // Operation codes carried by an input beat
  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } wfpa_op_t;

  // Input beat
  typedef struct packed {
    wfpa_op_t    operation;
    logic [3:0]  partition_index;
    logic [15:0] size;
  } wfpa_in_t;

  // Result beat
  typedef struct packed {
    logic       granted;
    logic [3:0] granted_index;
  } wfpa_out_t;

  // Search token walking down the cell row
  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [SIZE_BITS-1:0] best_size;
    logic [IDX_W-1:0]     best_idx;
    logic [SIZE_BITS-1:0] req_size;
  } wfpa_tok_t;

  // Table update broadcast to every cell
  typedef struct packed {
    logic                 wr_en;
    logic                 clr_en;
    logic [IDX_W-1:0]     sel_idx;
    logic [SIZE_BITS-1:0] wr_size;
  } wfpa_ctl_t;

  // Fit an input size field to the stored size width
  function automatic logic [SIZE_BITS-1:0] fit_size(input logic [15:0] sz);
    return SIZE_BITS'(sz);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/wfpa_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module wfpa_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [wfpa_pkg::IDX_W-1:0] cell_idx,
  input  wire wfpa_pkg::wfpa_ctl_t      ctl,
  input  wire wfpa_pkg::wfpa_tok_t      tok_in,
  output wfpa_pkg::wfpa_tok_t           tok_out
);

  logic [wfpa_pkg::SIZE_BITS-1:0] size_r;
  logic                           free_r;
  logic                           free_nxt;
  wfpa_pkg::wfpa_tok_t            tok_r;
  wfpa_pkg::wfpa_tok_t            tok_nxt;
  logic                           hit;
  logic                           fits;
  logic                           take;

  assign hit = (ctl.sel_idx == cell_idx);

  // Update the free mark: load sets it, grant drops it
  always_comb begin
    free_nxt = free_r;
    if (ctl.wr_en && hit) begin
      free_nxt = 1'b1;
    end else if (ctl.clr_en && hit) begin
      free_nxt = 1'b0;
    end
  end

  // Compare this entry against the passing token; strict greater keeps the lower index
  assign fits = free_r && (size_r >= tok_in.req_size);
  assign take = fits && (!tok_in.found || (size_r > tok_in.best_size));

  always_comb begin
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.best_size = size_r;
      tok_nxt.best_idx  = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      free_r      <= free_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
    // Hold size and token payload without reset
    if (ctl.wr_en && hit) begin
      size_r <= ctl.wr_size;
    end
    tok_r.found     <= tok_nxt.found;
    tok_r.best_size <= tok_nxt.best_size;
    tok_r.best_idx  <= tok_nxt.best_idx;
    tok_r.req_size  <= tok_nxt.req_size;
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// File: rtl/core/worst_fit_partition_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Load beat: result strobes in the cycle after acceptance; busy stays low, so loads go 1 per cycle.
// Request beat: a search token walks the row of PARTITIONS cells, one cell per cycle,
// then the grant cycle marks the entry used and registers the result; the result strobes
// in the same cycle that busy falls and the next beat can be taken, so requests do not overlap.
// The receiver cannot stall; results are one-cycle strobes.
// Synchronous active-low reset marks every partition used (none available).
module worst_fit_partition_allocator (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire wfpa_pkg::wfpa_in_t in_data,
  output logic                   out_valid,
  output wfpa_pkg::wfpa_out_t    out_data
);

  wfpa_pkg::wfpa_tok_t tok [wfpa_pkg::PARTITIONS+1];
  wfpa_pkg::wfpa_tok_t head;
  wfpa_pkg::wfpa_ctl_t ctl;
  wfpa_pkg::wfpa_tok_t tail;
  wfpa_pkg::wfpa_out_t out_data_r;
  wfpa_pkg::wfpa_out_t out_data_nxt;
  logic                busy_r;
  logic                busy_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                accept;
  logic                is_load;
  logic                in_range;

  assign accept   = start && !busy_r;
  assign is_load  = (in_data.operation == wfpa_pkg::OP_LOAD);
  assign in_range = (32'(in_data.partition_index) < wfpa_pkg::PARTITIONS);
  assign tail     = tok[wfpa_pkg::PARTITIONS];

  // Launch a search token for an accepted request
  always_comb begin
    head.valid     = accept && !is_load;
    head.found     = 1'b0;
    head.best_size = '0;
    head.best_idx  = '0;
    head.req_size  = wfpa_pkg::fit_size(in_data.size);
  end

  assign tok[0] = head;

  // Broadcast table updates: load write or grant clear (never in the same cycle)
  always_comb begin
    ctl.wr_en   = accept && is_load && in_range;
    ctl.clr_en  = tail.valid && tail.found;
    ctl.wr_size = wfpa_pkg::fit_size(in_data.size);
    if (tail.valid) begin
      ctl.sel_idx = tail.best_idx;
    end else begin
      ctl.sel_idx = wfpa_pkg::IDX_W'(in_data.partition_index);
    end
  end

  // Row of cells
  for (genvar i = 0; i < wfpa_pkg::PARTITIONS; i++) begin : g_cell
    wfpa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (wfpa_pkg::IDX_W'(i)),
      .ctl      (ctl),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  // Form the result beat and track busy
  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    if (tail.valid) begin
      busy_nxt                   = 1'b0;
      out_valid_nxt              = 1'b1;
      out_data_nxt.granted       = tail.found;
      out_data_nxt.granted_index = tail.found ? 4'(tail.best_idx) : 4'd0;
    end else if (accept) begin
      if (is_load) begin
        out_valid_nxt        = 1'b1;
        out_data_nxt.granted = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/core/wfpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wfpa_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire wfpa_pkg::wfpa_in_t  in_data,
  input wire logic                out_valid,
  input wire wfpa_pkg::wfpa_out_t out_data
);

  // A load answers with a grant in the next cycle
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.operation == wfpa_pkg::OP_LOAD)
      |=> (out_valid && out_data.granted))
    else $error("load beat did not produce a grant");

  // A request holds the block busy
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.operation == wfpa_pkg::OP_REQUEST) |=> busy)
    else $error("request accepted without going busy");

  // No result strobes while a search is in flight
  a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe during search");

  // End of a search always delivers its result
  a_fell_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("search ended without a result");

  // A refused request reports index zero
  a_refused_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.granted) |-> (out_data.granted_index == 4'd0))
    else $error("refused request with nonzero index");

endmodule

bind worst_fit_partition_allocator wfpa_checker u_wfpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
